// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the ellipse unit checker.
// No dependencies; included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication into the next cycle, quiet while reset is held.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Same-cycle implication, also checked during reset.
`define CHK_NOW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/cee_pkg.sv =====
// Package for the covariance error ellipse unit: word types, opcodes, constants.
// No dependencies.
package cee_pkg;

    localparam int unsigned SCALE_W      = 24;
    localparam int unsigned SQRT_STEPS   = 33;
    localparam int unsigned CORDIC_STEPS = 20;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd392626;
    localparam logic [1:0] ADDR_SCALE  = 2'd0;
    localparam logic signed [24:0] PI_Q20      = 25'sd3294199;
    localparam logic signed [14:0] HALF_PI_Q13 = 15'sd12868;
    localparam logic signed [47:0] NORM_LIM    = 48'sh010000000000;

    typedef struct packed {
        logic        opcode;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] cov_xx;
        logic [31:0] cov_yx;
        logic [31:0] cov_yy;
    } in_word_t;

    typedef struct packed {
        logic        channel;
        logic [31:0] centre_x;
        logic [31:0] centre_y;
        logic [14:0] angle;
        logic [31:0] major_axis;
        logic [31:0] minor_axis;
    } out_word_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_COMMIT, OP_MUL_D, OP_MUL_B, OP_R_START, OP_SQ_STEP,
        OP_R_SAVE, OP_C_LOAD, OP_C_NORM, OP_C_ROT, OP_A_LO, OP_A_HI, OP_A_START,
        OP_MJ_SAVE, OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] idx;
        logic       minor;
    } cmd_t;

    typedef struct packed {
        logic dup;
        logic bzero;
        logic neg;
        logic norm_done;
        logic out_free;
    } status_t;

    function automatic logic [24:0] atan_q20(input logic [4:0] i);
        logic [24:0] v;
        case (i)
            5'd0:  v = 25'd823550;
            5'd1:  v = 25'd486170;
            5'd2:  v = 25'd256879;
            5'd3:  v = 25'd130396;
            5'd4:  v = 25'd65451;
            5'd5:  v = 25'd32757;
            5'd6:  v = 25'd16383;
            5'd7:  v = 25'd8192;
            5'd8:  v = 25'd4096;
            5'd9:  v = 25'd2048;
            5'd10: v = 25'd1024;
            5'd11: v = 25'd512;
            5'd12: v = 25'd256;
            5'd13: v = 25'd128;
            5'd14: v = 25'd64;
            5'd15: v = 25'd32;
            5'd16: v = 25'd16;
            5'd17: v = 25'd8;
            5'd18: v = 25'd4;
            5'd19: v = 25'd2;
            default: v = 25'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/cee_ctrl.sv =====
// Sequencer for the ellipse unit: steps the datapath through each word.
// Depends on cee_pkg.
module cee_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  cee_pkg::status_t status,
    output cee_pkg::cmd_t    cmd
);
    import cee_pkg::*;

    typedef enum logic [19:0] {
        ST_IDLE    = 20'h00001,
        ST_CHECK   = 20'h00002,
        ST_MULD    = 20'h00004,
        ST_MULB    = 20'h00008,
        ST_RSTART  = 20'h00010,
        ST_RSQRT   = 20'h00020,
        ST_RSAVE   = 20'h00040,
        ST_CLOAD   = 20'h00080,
        ST_CNORM   = 20'h00100,
        ST_CROT    = 20'h00200,
        ST_MJLO    = 20'h00400,
        ST_MJHI    = 20'h00800,
        ST_MJSTART = 20'h01000,
        ST_MJSQRT  = 20'h02000,
        ST_MJSAVE  = 20'h04000,
        ST_MNLO    = 20'h08000,
        ST_MNHI    = 20'h10000,
        ST_MNSTART = 20'h20000,
        ST_MNSQRT  = 20'h40000,
        ST_DONE    = 20'h80000
    } state_t;

    localparam logic [5:0] SQ_LAST = 6'(SQRT_STEPS - 1);
    localparam logic [5:0] CR_LAST = 6'(CORDIC_STEPS - 1);

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = '0;
        s_ready    = 1'b0;
        cmd.op     = OP_NONE;
        cmd.idx    = cnt_reg[4:0];
        cmd.minor  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.dup) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.op     = OP_COMMIT;
                    state_next = ST_MULD;
                end
            end
            ST_MULD: begin
                cmd.op     = OP_MUL_D;
                state_next = ST_MULB;
            end
            ST_MULB: begin
                cmd.op     = OP_MUL_B;
                state_next = ST_RSTART;
            end
            ST_RSTART: begin
                cmd.op     = OP_R_START;
                state_next = ST_RSQRT;
            end
            ST_RSQRT: begin
                cmd.op   = OP_SQ_STEP;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == SQ_LAST) state_next = ST_RSAVE;
            end
            ST_RSAVE: begin
                cmd.op     = OP_R_SAVE;
                state_next = status.bzero ? ST_MJLO : ST_CLOAD;
            end
            ST_CLOAD: begin
                cmd.op     = OP_C_LOAD;
                state_next = ST_CNORM;
            end
            ST_CNORM: begin
                cmd.op = OP_C_NORM;
                if (status.norm_done) state_next = ST_CROT;
            end
            ST_CROT: begin
                cmd.op   = OP_C_ROT;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == CR_LAST) state_next = ST_MJLO;
            end
            ST_MJLO: begin
                cmd.op     = OP_A_LO;
                state_next = ST_MJHI;
            end
            ST_MJHI: begin
                cmd.op     = OP_A_HI;
                state_next = ST_MJSTART;
            end
            ST_MJSTART: begin
                cmd.op     = OP_A_START;
                state_next = ST_MJSQRT;
            end
            ST_MJSQRT: begin
                cmd.op   = OP_SQ_STEP;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == SQ_LAST) state_next = ST_MJSAVE;
            end
            ST_MJSAVE: begin
                cmd.op     = OP_MJ_SAVE;
                state_next = status.neg ? ST_DONE : ST_MNLO;
            end
            ST_MNLO: begin
                cmd.op     = OP_A_LO;
                cmd.minor  = 1'b1;
                state_next = ST_MNHI;
            end
            ST_MNHI: begin
                cmd.op     = OP_A_HI;
                cmd.minor  = 1'b1;
                state_next = ST_MNSTART;
            end
            ST_MNSTART: begin
                cmd.op     = OP_A_START;
                state_next = ST_MNSQRT;
            end
            ST_MNSQRT: begin
                cmd.op   = OP_SQ_STEP;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == SQ_LAST) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/cee_datapath.sv =====
// Datapath for the ellipse unit: shared multiplier, bit-serial square root,
// vectoring CORDIC, channel history and the output register. Depends on cee_pkg.
module cee_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cee_pkg::cmd_t                cmd,
    output cee_pkg::status_t             status,
    input  logic [cee_pkg::SCALE_W-1:0]  scale,
    input  cee_pkg::in_word_t            s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output cee_pkg::out_word_t           m_data
);
    import cee_pkg::*;

    in_word_t    in_reg;
    logic [31:0] last_x_reg [2];
    logic [1:0]  seen_reg;

    logic [63:0] prod_reg, acc_reg;
    logic [65:0] rad_reg;
    logic [32:0] root_reg;
    logic [35:0] rem_reg;
    logic [32:0] r_reg;
    logic [31:0] major_reg;

    logic signed [47:0] cx_reg, cy_reg;
    logic signed [24:0] cz_reg;

    out_word_t out_reg;
    logic      m_valid_reg;

    // operand conditioning
    logic signed [32:0] d, neg_d;
    logic [32:0] s, neg_b;
    logic [31:0] abs_d, abs_b;
    logic [34:0] t_sum, t_dif, t;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod_next;

    assign d     = $signed({1'b0, in_reg.cov_xx}) - $signed({1'b0, in_reg.cov_yy});
    assign neg_d = -d;
    assign abs_d = d[32] ? neg_d[31:0] : d[31:0];
    assign neg_b = -{in_reg.cov_yx[31], in_reg.cov_yx};
    assign abs_b = in_reg.cov_yx[31] ? neg_b[31:0] : in_reg.cov_yx;
    assign s     = {1'b0, in_reg.cov_xx} + {1'b0, in_reg.cov_yy};
    assign t_sum = {2'b0, s} + {2'b0, r_reg};
    assign t_dif = {2'b0, s} - {2'b0, r_reg};
    assign t     = cmd.minor ? t_dif : t_sum;

    always_comb begin
        mul_a = abs_d;
        mul_b = abs_d;
        case (cmd.op)
            OP_MUL_B: begin
                mul_a = abs_b;
                mul_b = abs_b;
            end
            OP_A_LO: begin
                mul_a = {8'b0, scale};
                mul_b = {15'b0, t[16:0]};
            end
            OP_A_HI: begin
                mul_a = {8'b0, scale};
                mul_b = {14'b0, t[34:17]};
            end
            default: ;
        endcase
    end
    assign prod_next = mul_a * mul_b;

    // square root, one result bit a cycle
    logic [35:0] rem_sh, trial;
    assign rem_sh = {rem_reg[33:0], rad_reg[65:64]};
    assign trial  = {1'b0, root_reg, 2'b01};

    // CORDIC helpers
    logic signed [47:0] xs, ys;
    logic signed [24:0] atan_v;
    logic in_range;
    assign xs     = cx_reg >>> cmd.idx;
    assign ys     = cy_reg >>> cmd.idx;
    assign atan_v = $signed(atan_q20(cmd.idx));
    assign in_range = (cx_reg < NORM_LIM) && (cx_reg > -NORM_LIM)
                   && (cy_reg < NORM_LIM) && (cy_reg > -NORM_LIM);

    // angle rounding, half away from zero, then clamp; fixed angle for zero covariance
    logic [24:0] abs_z, neg_z;
    logic [24:0] rnd_z;
    logic signed [17:0] q;
    logic signed [14:0] ang_c, ang;
    assign neg_z = -cz_reg;
    assign abs_z = cz_reg[24] ? neg_z : cz_reg;
    assign rnd_z = (abs_z + 25'd128) >> 8;
    assign q     = cz_reg[24] ? -$signed({1'b0, rnd_z[16:0]}) : $signed({1'b0, rnd_z[16:0]});
    always_comb begin
        if (q > 18'(HALF_PI_Q13))       ang_c = HALF_PI_Q13;
        else if (q < -18'(HALF_PI_Q13)) ang_c = -HALF_PI_Q13;
        else                            ang_c = q[14:0];
        if (in_reg.cov_yx == 32'd0)
            ang = (in_reg.cov_yy >= in_reg.cov_xx) ? HALF_PI_Q13 : 15'sd0;
        else
            ang = ang_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_COMMIT) seen_reg[in_reg.opcode] <= 1'b1;
            if (cmd.op == OP_OUT)    m_valid_reg <= 1'b1;
            else if (m_ready)        m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD:   in_reg <= s_data;
            OP_COMMIT: last_x_reg[in_reg.opcode] <= in_reg.pos_x;
            OP_MUL_D:  prod_reg <= prod_next;
            OP_MUL_B: begin
                prod_reg <= prod_next;
                acc_reg  <= prod_reg;
            end
            OP_R_START: begin
                rad_reg  <= {2'b0, acc_reg} + {prod_reg, 2'b00};
                root_reg <= '0;
                rem_reg  <= '0;
            end
            OP_SQ_STEP: begin
                rad_reg <= {rad_reg[63:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[31:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[31:0], 1'b0};
                end
            end
            OP_R_SAVE: r_reg <= root_reg;
            OP_C_LOAD: begin
                cx_reg <= 48'(d);
                cy_reg <= {{15{in_reg.cov_yx[31]}}, in_reg.cov_yx, 1'b0};
                cz_reg <= '0;
            end
            OP_C_NORM: begin
                if (in_range) begin
                    cx_reg <= {cx_reg[46:0], 1'b0};
                    cy_reg <= {cy_reg[46:0], 1'b0};
                end else if (cx_reg[47]) begin
                    cx_reg <= -cx_reg;
                    cy_reg <= -cy_reg;
                    cz_reg <= cy_reg[47] ? -PI_Q20 : PI_Q20;
                end
            end
            OP_C_ROT: begin
                if (!cy_reg[47]) begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + atan_v;
                end else begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - atan_v;
                end
            end
            OP_A_LO: prod_reg <= prod_next;
            OP_A_HI: begin
                prod_reg <= prod_next;
                acc_reg  <= prod_reg;
            end
            OP_A_START: begin
                // 2 * scale * t, from the two partial products
                rad_reg  <= {5'b0, ({1'b0, acc_reg[58:0]} + {prod_reg[42:0], 17'b0}), 1'b0};
                root_reg <= '0;
                rem_reg  <= '0;
            end
            OP_MJ_SAVE: major_reg <= root_reg[31:0];
            OP_OUT: begin
                out_reg.channel    <= in_reg.opcode;
                out_reg.centre_x   <= in_reg.pos_x;
                out_reg.centre_y   <= in_reg.pos_y;
                out_reg.angle      <= ang;
                out_reg.major_axis <= major_reg;
                out_reg.minor_axis <= status.neg ? 32'd0 : root_reg[31:0];
            end
            default: ;
        endcase
    end

    assign status.dup       = seen_reg[in_reg.opcode]
                           && (last_x_reg[in_reg.opcode] == in_reg.pos_x);
    assign status.bzero     = (in_reg.cov_yx == 32'd0);
    assign status.neg       = (s < r_reg);
    assign status.norm_done = !in_range;
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/core/covariance_error_ellipse_unit.sv =====
// Covariance error ellipse: one word at a time, up to three 33-step square roots, a
// CORDIC normalisation and 20 rotations per word (no CORDIC for zero covariance).
// A repeated x is dropped without a result. The next word is taken the cycle after
// the result is loaded into the output register, which waits while an unaccepted
// result is held there; no new word is taken before the last one is through.
// Sync active-low reset clears sequencer, channel history, output valid; scale 5.991.
module covariance_error_ellipse_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cee_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cee_pkg::out_word_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import cee_pkg::*;

    logic [SCALE_W-1:0] scale_reg;
    cmd_t    cmd;
    status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_SCALE) begin
            scale_reg <= pwdata[SCALE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SCALE) ? {8'b0, scale_reg} : 32'd0;

    cee_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cee_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .scale   (scale_reg),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== rtl/core/cee_checker.sv =====
// Port-level checker for the ellipse unit, bound to the top level.
// Depends on cee_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cee_props (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input cee_pkg::in_word_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input cee_pkg::out_word_t m_data,
    input logic               pready
);
    import cee_pkg::*;

    `CHK_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `CHK_NEXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_data))
    `CHK_NEXT(a_busy_after_take, aclk, aresetn, s_valid && s_ready, !s_ready)
    `CHK_NEXT(a_reset_clears, aclk, 1'b1, !aresetn, !m_valid)
    `CHK_NOW(a_pready_high, aclk, 1'b1, pready)

endmodule

bind covariance_error_ellipse_unit cee_props u_chk (.*);
